[rtl/sqvg_pkg.sv]
// Shared constants and the front-to-back quad descriptor for the sprite quad generator.
package sqvg_pkg;

    localparam int DEFAULT_SINE_TABLE_DEPTH = 1024;

    // Angle: two quadrant bits above ANGLE_FRAC_BITS bits of position in the quadrant.
    localparam int ANGLE_FRAC_BITS = 14;

    localparam logic [63:0]        HALF_PI_Q30 = 64'd1686629713;
    localparam logic signed [64:0] Q30_ONE     = 65'sd1073741824;

    // Taylor divisors (2n)(2n+1) for n = 1..8.
    localparam logic [63:0] TAYLOR_DIV [8] = '{
        64'd6, 64'd20, 64'd42, 64'd72, 64'd110, 64'd156, 64'd210, 64'd272
    };

    localparam logic [1:0] QUAD_0 = 2'd0;
    localparam logic [1:0] QUAD_1 = 2'd1;
    localparam logic [1:0] QUAD_2 = 2'd2;
    localparam logic [1:0] QUAD_3 = 2'd3;

    localparam logic [1:0] CORNER_TL = 2'd0;
    localparam logic [1:0] CORNER_TR = 2'd1;
    localparam logic [1:0] CORNER_BR = 2'd2;
    localparam logic [1:0] CORNER_BL = 2'd3;

    // One sprite, reduced to the four rotation products and the shifted anchor.
    typedef struct packed {
        logic signed [63:0] wc;
        logic signed [63:0] hs;
        logic signed [63:0] ws;
        logic signed [63:0] hc;
        logic signed [33:0] base_x;
        logic signed [33:0] base_y;
        logic [16:0]        u_left;
        logic [16:0]        v_top;
        logic [16:0]        u_right;
        logic [16:0]        v_bottom;
        logic [31:0]        tint;
        logic               region_rotated;
    } sqvg_quad_t;

endpackage

[rtl/sqvg_sine_rom.sv]
// Quarter-wave sine ROM with two registered read ports.
module sqvg_sine_rom #(
    parameter int SINE_TABLE_DEPTH = sqvg_pkg::DEFAULT_SINE_TABLE_DEPTH,
    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1)
) (
    input  logic              aclk,
    input  logic              en,
    input  logic [ADDR_W-1:0] sin_addr,
    input  logic [ADDR_W-1:0] cos_addr,
    output logic [30:0]       sin_data,
    output logic [30:0]       cos_data
);
    import sqvg_pkg::*;

    // Entry k holds sin(k/DEPTH * pi/2) in Q1.30 from a nine-term series.
    function automatic logic [30:0] sin_entry(input int k);
        logic [63:0]        x;
        logic [63:0]        mag;
        logic signed [64:0] acc;
        begin
            x   = (HALF_PI_Q30 * 64'(k) + 64'(SINE_TABLE_DEPTH / 2)) / SINE_TABLE_DEPTH;
            acc = $signed({1'b0, x});
            mag = x;
            for (int n = 1; n <= 8; n++) begin
                mag = (mag * x) >> 30;
                mag = (mag * x) >> 30;
                mag = mag / TAYLOR_DIV[n-1];
                if ((n % 2) == 1) begin
                    acc = acc - $signed({1'b0, mag});
                end else begin
                    acc = acc + $signed({1'b0, mag});
                end
            end
            if (acc < 0) begin
                acc = '0;
            end
            if (acc > Q30_ONE) begin
                acc = Q30_ONE;
            end
            return acc[30:0];
        end
    endfunction

    logic [30:0] rom_words [SINE_TABLE_DEPTH+1];
    logic [30:0] sin_data_reg;
    logic [30:0] cos_data_reg;

    for (genvar k = 0; k <= SINE_TABLE_DEPTH; k++) begin : g_rom
        assign rom_words[k] = sin_entry(k);
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            sin_data_reg <= rom_words[sin_addr];
            cos_data_reg <= rom_words[cos_addr];
        end
    end

    assign sin_data = sin_data_reg;
    assign cos_data = cos_data_reg;

endmodule

[rtl/sqvg_front.sv]
// Front end: accept a sprite, look up sine and cosine, form the rotation products.
module sqvg_front #(
    parameter int SINE_TABLE_DEPTH = sqvg_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic signed [31:0]   s_pos_x,
    input  logic signed [31:0]   s_pos_y,
    input  logic [31:0]          s_width,
    input  logic [31:0]          s_height,
    input  logic [15:0]          s_angle,
    input  logic [16:0]          s_u_left,
    input  logic [16:0]          s_v_top,
    input  logic [16:0]          s_u_right,
    input  logic [16:0]          s_v_bottom,
    input  logic [31:0]          s_tint,
    input  logic [31:0]          s_pivot,
    input  logic                 s_region_rotated,
    input  logic                 s_valid,
    output logic                 s_ready,
    output logic                 push_valid,
    input  logic                 push_ready,
    output sqvg_pkg::sqvg_quad_t push_data
);
    import sqvg_pkg::*;

    localparam int ADDR_W = $clog2(SINE_TABLE_DEPTH + 1);
    localparam int PROD_W = ANGLE_FRAC_BITS + ADDR_W + 1;
    localparam logic [ADDR_W:0] IDX_MAX = (ADDR_W + 1)'(SINE_TABLE_DEPTH);

    typedef struct packed {
        logic [16:0] u_left;
        logic [16:0] v_top;
        logic [16:0] u_right;
        logic [16:0] v_bottom;
        logic [31:0] tint;
        logic        region_rotated;
    } pass_t;

    logic               en;

    // stage 1: captured word, table index
    logic               f1_valid_reg;
    logic signed [31:0] f1_pos_x_reg, f1_pos_y_reg;
    logic [31:0]        f1_width_reg, f1_height_reg, f1_pivot_reg;
    logic [1:0]         f1_quad_reg;
    logic [ADDR_W-1:0]  f1_idx_reg;
    pass_t              f1_pass_reg;

    // stage 2: table data, pivot products
    logic               f2_valid_reg;
    logic signed [31:0] f2_pos_x_reg, f2_pos_y_reg;
    logic [31:0]        f2_width_reg, f2_height_reg;
    logic [1:0]         f2_quad_reg;
    logic signed [48:0] f2_ox_prod_reg, f2_oy_prod_reg;
    pass_t              f2_pass_reg;

    // stage 3: descriptor ready for the queue
    logic               f3_valid_reg;
    sqvg_quad_t         f3_data_reg;

    logic [PROD_W-1:0]  idx_prod;
    logic [ADDR_W:0]    idx_wide;
    logic [ADDR_W-1:0]  idx_next;
    logic [ADDR_W-1:0]  cos_addr;
    logic [30:0]        sin_raw, cos_raw;

    logic signed [15:0] piv_x, piv_y;
    logic signed [32:0] f1_w_s, f1_h_s;
    logic signed [48:0] ox_prod_next, oy_prod_next;

    logic signed [31:0] ts, tc, s_val, c_val;
    logic signed [32:0] f2_w_s, f2_h_s;
    logic signed [64:0] wc_full, hs_full, ws_full, hc_full;
    logic signed [48:0] ox_round, oy_round;
    logic signed [32:0] ox, oy;
    sqvg_quad_t         f3_data_next;

    // Advance the whole front together; hold only when the queue refuses a finished word.
    assign en         = !f3_valid_reg || push_ready;
    assign s_ready    = en;
    assign push_valid = f3_valid_reg;
    assign push_data  = f3_data_reg;

    // Table index: round q * DEPTH / 2^14, clamp at DEPTH.
    assign idx_prod = PROD_W'(s_angle[ANGLE_FRAC_BITS-1:0]) * PROD_W'(SINE_TABLE_DEPTH)
                    + PROD_W'(1 << (ANGLE_FRAC_BITS - 1));
    assign idx_wide = idx_prod[PROD_W-1:ANGLE_FRAC_BITS];
    assign idx_next = (idx_wide > IDX_MAX) ? IDX_MAX[ADDR_W-1:0] : idx_wide[ADDR_W-1:0];
    assign cos_addr = IDX_MAX[ADDR_W-1:0] - f1_idx_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            f1_valid_reg <= 1'b0;
            f2_valid_reg <= 1'b0;
            f3_valid_reg <= 1'b0;
        end else if (en) begin
            f1_valid_reg <= s_valid;
            f2_valid_reg <= f1_valid_reg;
            f3_valid_reg <= f2_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f1_pos_x_reg               <= s_pos_x;
            f1_pos_y_reg               <= s_pos_y;
            f1_width_reg               <= s_width;
            f1_height_reg              <= s_height;
            f1_pivot_reg               <= s_pivot;
            f1_quad_reg                <= s_angle[15:14];
            f1_idx_reg                 <= idx_next;
            f1_pass_reg.u_left         <= s_u_left;
            f1_pass_reg.v_top          <= s_v_top;
            f1_pass_reg.u_right        <= s_u_right;
            f1_pass_reg.v_bottom       <= s_v_bottom;
            f1_pass_reg.tint           <= s_tint;
            f1_pass_reg.region_rotated <= s_region_rotated;
        end
    end

    sqvg_sine_rom #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_rom (
        .aclk    (aclk),
        .en      (en),
        .sin_addr(f1_idx_reg),
        .cos_addr(cos_addr),
        .sin_data(sin_raw),
        .cos_data(cos_raw)
    );

    // Pivot minus one half, as a signed Q0.16 value.
    assign piv_x        = $signed({~f1_pivot_reg[15], f1_pivot_reg[14:0]});
    assign piv_y        = $signed({~f1_pivot_reg[31], f1_pivot_reg[30:16]});
    assign f1_w_s       = $signed({1'b0, f1_width_reg});
    assign f1_h_s       = $signed({1'b0, f1_height_reg});
    assign ox_prod_next = piv_x * f1_w_s;
    assign oy_prod_next = piv_y * f1_h_s;

    always_ff @(posedge aclk) begin
        if (en) begin
            f2_pos_x_reg   <= f1_pos_x_reg;
            f2_pos_y_reg   <= f1_pos_y_reg;
            f2_width_reg   <= f1_width_reg;
            f2_height_reg  <= f1_height_reg;
            f2_quad_reg    <= f1_quad_reg;
            f2_ox_prod_reg <= ox_prod_next;
            f2_oy_prod_reg <= oy_prod_next;
            f2_pass_reg    <= f1_pass_reg;
        end
    end

    // Quarter-wave symmetry.
    assign ts = $signed({1'b0, sin_raw});
    assign tc = $signed({1'b0, cos_raw});

    always_comb begin
        unique case (f2_quad_reg)
            QUAD_0: begin
                s_val = ts;
                c_val = tc;
            end
            QUAD_1: begin
                s_val = tc;
                c_val = -ts;
            end
            QUAD_2: begin
                s_val = -ts;
                c_val = -tc;
            end
            default: begin
                s_val = -tc;
                c_val = ts;
            end
        endcase
    end

    assign f2_w_s   = $signed({1'b0, f2_width_reg});
    assign f2_h_s   = $signed({1'b0, f2_height_reg});
    assign wc_full  = f2_w_s * c_val;
    assign hs_full  = f2_h_s * s_val;
    assign ws_full  = f2_w_s * s_val;
    assign hc_full  = f2_h_s * c_val;

    assign ox_round = f2_ox_prod_reg + 49'sd32768;
    assign oy_round = f2_oy_prod_reg + 49'sd32768;
    assign ox       = ox_round[48:16];
    assign oy       = oy_round[48:16];

    always_comb begin
        f3_data_next.wc             = wc_full[63:0];
        f3_data_next.hs             = hs_full[63:0];
        f3_data_next.ws             = ws_full[63:0];
        f3_data_next.hc             = hc_full[63:0];
        f3_data_next.base_x         = $signed({{2{f2_pos_x_reg[31]}}, f2_pos_x_reg})
                                    - $signed({ox[32], ox});
        f3_data_next.base_y         = $signed({{2{f2_pos_y_reg[31]}}, f2_pos_y_reg})
                                    - $signed({oy[32], oy});
        f3_data_next.u_left         = f2_pass_reg.u_left;
        f3_data_next.v_top          = f2_pass_reg.v_top;
        f3_data_next.u_right        = f2_pass_reg.u_right;
        f3_data_next.v_bottom       = f2_pass_reg.v_bottom;
        f3_data_next.tint           = f2_pass_reg.tint;
        f3_data_next.region_rotated = f2_pass_reg.region_rotated;
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            f3_data_reg <= f3_data_next;
        end
    end

endmodule

[rtl/sqvg_queue.sv]
// Two-entry queue of sprite descriptors between front and back.
module sqvg_queue (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 push_valid,
    output logic                 push_ready,
    input  sqvg_pkg::sqvg_quad_t push_data,
    output logic                 pop_valid,
    input  logic                 pop_ready,
    output sqvg_pkg::sqvg_quad_t pop_data
);
    import sqvg_pkg::*;

    localparam int DEPTH = 2;
    localparam int PTR_W = $clog2(DEPTH);

    sqvg_quad_t       entries_reg [DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [PTR_W:0]   count_reg, count_next;
    logic             do_push, do_pop;

    assign push_ready = (count_reg != (PTR_W + 1)'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = entries_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        count_next = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 1'b1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            count_reg <= count_next;
            if (do_push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

endmodule

[rtl/sqvg_back.sv]
// Back end: step through the four corners, round, add the anchor, saturate.
module sqvg_back (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 pop_valid,
    output logic                 pop_ready,
    input  sqvg_pkg::sqvg_quad_t pop_data,
    output logic [1:0]           m_corner,
    output logic signed [31:0]   m_vert_x,
    output logic signed [31:0]   m_vert_y,
    output logic [16:0]          m_tex_u,
    output logic [16:0]          m_tex_v,
    output logic [31:0]          m_vert_color,
    output logic                 m_last_corner,
    output logic                 m_valid,
    input  logic                 m_ready
);
    import sqvg_pkg::*;

    localparam logic signed [34:0] SAT_MAX = 35'sd2147483647;
    localparam logic signed [34:0] SAT_MIN = -35'sd2147483648;
    localparam logic signed [64:0] ROUND_HALF = 65'sd1073741824;

    function automatic logic signed [31:0] sat32(input logic signed [34:0] v);
        logic signed [34:0] r;
        begin
            r = v;
            if (v > SAT_MAX) begin
                r = SAT_MAX;
            end else if (v < SAT_MIN) begin
                r = SAT_MIN;
            end
            return r[31:0];
        end
    endfunction

    logic [1:0]         cnt_reg;
    logic               b1_adv, out_adv, b1_load;

    logic               b1_valid_reg;
    logic signed [33:0] b1_rx_reg, b1_ry_reg, b1_base_x_reg, b1_base_y_reg;
    logic [16:0]        b1_u_reg, b1_v_reg;
    logic [31:0]        b1_tint_reg;
    logic [1:0]         b1_corner_reg;
    logic               b1_last_reg;

    logic               m_valid_reg;
    logic [1:0]         m_corner_reg;
    logic signed [31:0] m_vert_x_reg, m_vert_y_reg;
    logic [16:0]        m_tex_u_reg, m_tex_v_reg;
    logic [31:0]        m_vert_color_reg;
    logic               m_last_corner_reg;

    logic               neg_x, neg_y;
    logic signed [64:0] wc_e, hs_e, ws_e, hc_e;
    logic signed [64:0] rx_sum, ry_sum;
    logic [16:0]        u_sel, v_sel;
    logic signed [34:0] vx_sum, vy_sum;

    assign out_adv   = !m_valid_reg || m_ready;
    assign b1_adv    = !b1_valid_reg || out_adv;
    assign b1_load   = pop_valid && b1_adv;
    // Release the queue entry when its last corner enters the pipe.
    assign pop_ready = b1_adv && (cnt_reg == CORNER_BL);

    // Corner signs: left half for TL and BL, top half for TL and TR.
    always_comb begin
        unique case (cnt_reg)
            CORNER_TL: begin
                neg_x = 1'b1;
                neg_y = 1'b1;
            end
            CORNER_TR: begin
                neg_x = 1'b0;
                neg_y = 1'b1;
            end
            CORNER_BR: begin
                neg_x = 1'b0;
                neg_y = 1'b0;
            end
            default: begin
                neg_x = 1'b1;
                neg_y = 1'b0;
            end
        endcase
    end

    assign wc_e   = {pop_data.wc[63], pop_data.wc};
    assign hs_e   = {pop_data.hs[63], pop_data.hs};
    assign ws_e   = {pop_data.ws[63], pop_data.ws};
    assign hc_e   = {pop_data.hc[63], pop_data.hc};

    assign rx_sum = (neg_x ? -wc_e : wc_e) + (neg_y ? hs_e : -hs_e) + ROUND_HALF;
    assign ry_sum = (neg_x ? -ws_e : ws_e) + (neg_y ? -hc_e : hc_e) + ROUND_HALF;

    always_comb begin
        if (pop_data.region_rotated) begin
            u_sel = (cnt_reg == CORNER_TL || cnt_reg == CORNER_TR)
                  ? pop_data.u_left : pop_data.u_right;
            v_sel = (cnt_reg == CORNER_TL || cnt_reg == CORNER_BL)
                  ? pop_data.v_bottom : pop_data.v_top;
        end else begin
            u_sel = (cnt_reg == CORNER_TL || cnt_reg == CORNER_BL)
                  ? pop_data.u_left : pop_data.u_right;
            v_sel = (cnt_reg == CORNER_TL || cnt_reg == CORNER_TR)
                  ? pop_data.v_top : pop_data.v_bottom;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg      <= CORNER_TL;
            b1_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            if (b1_load) begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            if (b1_adv) begin
                b1_valid_reg <= pop_valid;
            end
            if (out_adv) begin
                m_valid_reg <= b1_valid_reg;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (b1_load) begin
            b1_rx_reg     <= rx_sum[64:31];
            b1_ry_reg     <= ry_sum[64:31];
            b1_base_x_reg <= pop_data.base_x;
            b1_base_y_reg <= pop_data.base_y;
            b1_u_reg      <= u_sel;
            b1_v_reg      <= v_sel;
            b1_tint_reg   <= pop_data.tint;
            b1_corner_reg <= cnt_reg;
            b1_last_reg   <= (cnt_reg == CORNER_BL);
        end
    end

    assign vx_sum = $signed({b1_base_x_reg[33], b1_base_x_reg})
                  + $signed({b1_rx_reg[33], b1_rx_reg});
    assign vy_sum = $signed({b1_base_y_reg[33], b1_base_y_reg})
                  + $signed({b1_ry_reg[33], b1_ry_reg});

    always_ff @(posedge aclk) begin
        if (out_adv && b1_valid_reg) begin
            m_corner_reg      <= b1_corner_reg;
            m_vert_x_reg      <= sat32(vx_sum);
            m_vert_y_reg      <= sat32(vy_sum);
            m_tex_u_reg       <= b1_u_reg;
            m_tex_v_reg       <= b1_v_reg;
            m_vert_color_reg  <= b1_tint_reg;
            m_last_corner_reg <= b1_last_reg;
        end
    end

    assign m_valid       = m_valid_reg;
    assign m_corner      = m_corner_reg;
    assign m_vert_x      = m_vert_x_reg;
    assign m_vert_y      = m_vert_y_reg;
    assign m_tex_u       = m_tex_u_reg;
    assign m_tex_v       = m_tex_v_reg;
    assign m_vert_color  = m_vert_color_reg;
    assign m_last_corner = m_last_corner_reg;

endmodule

[rtl/sprite_quad_vertex_generator.sv]
// Top level of the rotated sprite quad vertex generator.
//
//   Channel   Direction  Handshake          Word
//   s_*       in         s_valid/s_ready    one sprite: anchor, size, angle, uv box, tint, pivot
//   m_*       out        m_valid/m_ready    one vertex: corner, x, y, u, v, color, last flag
//
// Each sprite yields four vertices (top-left, top-right, bottom-right, bottom-left),
// one per step of the corner counter in the back end, which takes a new sprite from
// the queue only once the last corner of the one before has entered its pipe.
// From acceptance to the first vertex a sprite passes three front stages
// (index, sine ROM read, multipliers), one queue slot, a rounding stage and the
// output register. Reset is synchronous, active low, and empties every stage.
// A stalled m_ready first fills the back end, then the two-entry queue, and only
// then drops s_ready; the front takes new sprites while vertices wait.
module sprite_quad_vertex_generator #(
    parameter int SINE_TABLE_DEPTH = sqvg_pkg::DEFAULT_SINE_TABLE_DEPTH
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic signed [31:0] s_pos_x,
    input  logic signed [31:0] s_pos_y,
    input  logic [31:0]        s_width,
    input  logic [31:0]        s_height,
    input  logic [15:0]        s_angle,
    input  logic [16:0]        s_u_left,
    input  logic [16:0]        s_v_top,
    input  logic [16:0]        s_u_right,
    input  logic [16:0]        s_v_bottom,
    input  logic [31:0]        s_tint,
    input  logic [31:0]        s_pivot,
    input  logic               s_region_rotated,
    input  logic               s_valid,
    output logic               s_ready,
    output logic [1:0]         m_corner,
    output logic signed [31:0] m_vert_x,
    output logic signed [31:0] m_vert_y,
    output logic [16:0]        m_tex_u,
    output logic [16:0]        m_tex_v,
    output logic [31:0]        m_vert_color,
    output logic               m_last_corner,
    output logic               m_valid,
    input  logic               m_ready
);
    import sqvg_pkg::*;

    // Front to queue.
    logic       push_valid, push_ready;
    sqvg_quad_t push_data;

    // Queue to back.
    logic       pop_valid, pop_ready;
    sqvg_quad_t pop_data;

    // Accept sprites, fetch sine/cosine, form the four rotation products and the
    // pivot-shifted anchor.
    sqvg_front #(
        .SINE_TABLE_DEPTH(SINE_TABLE_DEPTH)
    ) u_front (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .s_pos_x         (s_pos_x),
        .s_pos_y         (s_pos_y),
        .s_width         (s_width),
        .s_height        (s_height),
        .s_angle         (s_angle),
        .s_u_left        (s_u_left),
        .s_v_top         (s_v_top),
        .s_u_right       (s_u_right),
        .s_v_bottom      (s_v_bottom),
        .s_tint          (s_tint),
        .s_pivot         (s_pivot),
        .s_region_rotated(s_region_rotated),
        .s_valid         (s_valid),
        .s_ready         (s_ready),
        .push_valid      (push_valid),
        .push_ready      (push_ready),
        .push_data       (push_data)
    );

    // Decouple the front, one sprite per cycle while the queue takes its words, from the four-per-sprite back.
    sqvg_queue u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_data (push_data),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data)
    );

    // Walk the corners, round the rotated offsets, add the anchor and saturate.
    sqvg_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .pop_valid    (pop_valid),
        .pop_ready    (pop_ready),
        .pop_data     (pop_data),
        .m_corner     (m_corner),
        .m_vert_x     (m_vert_x),
        .m_vert_y     (m_vert_y),
        .m_tex_u      (m_tex_u),
        .m_tex_v      (m_tex_v),
        .m_vert_color (m_vert_color),
        .m_last_corner(m_last_corner),
        .m_valid      (m_valid),
        .m_ready      (m_ready)
    );

endmodule
